### src/rtte_pkg.sv
// ----------------------------------------------------------------------------
// rtte_pkg
// Shared widths, reset values and register indexes for the RTT estimator.
// ----------------------------------------------------------------------------
package rtte_pkg;

  localparam int RTT_BITS_DEF = 20;   // default RTT field width
  localparam int CNT_W        = 4;    // PTO backoff exponent width
  localparam int CNT_MAX      = (2 ** CNT_W) - 1;
  localparam int PTO_W        = 32;   // PTO duration width
  localparam int MAD_W        = 14;   // peer max delay register width
  localparam int GRAN_W       = 8;    // timer_granularity register width

  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = MAD_W;

  localparam logic [MAD_W-1:0]  MAD_RESET  = MAD_W'(25);
  localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(1);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PEER_DELAY = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_TIMER_GRAN = CFG_ADDR_W'(1);

endpackage

### src/rtte_update.sv
// ----------------------------------------------------------------------------
// rtte_update
// Estimator state (smoothed, variance, minimum) and its one-sample update.
// ----------------------------------------------------------------------------
module rtte_update #(
  parameter int RTT_BITS = rtte_pkg::RTT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [RTT_BITS-1:0]        sample,
  input  logic [RTT_BITS-1:0]        delay,
  input  logic [rtte_pkg::CNT_W-1:0] backoff,
  output logic [RTT_BITS-1:0]        smoothed,
  output logic [RTT_BITS-1:0]        variance,
  output logic [RTT_BITS-1:0]        min_rtt,
  output logic [rtte_pkg::CNT_W-1:0] backoff_o
);

  logic [RTT_BITS-1:0]        smoothed_r, smoothed_nxt;
  logic [RTT_BITS-1:0]        variance_r, variance_nxt;
  logic [RTT_BITS-1:0]        min_rtt_r, min_rtt_nxt;
  logic [rtte_pkg::CNT_W-1:0] backoff_r;

  logic                seeded;
  logic [RTT_BITS-1:0] min_upd;
  logic [RTT_BITS:0]   thresh;
  logic [RTT_BITS-1:0] adj;
  logic [RTT_BITS-1:0] diff;
  logic [RTT_BITS+1:0] var_sum;
  logic [RTT_BITS+2:0] srtt_sum;

  always_comb begin
    seeded  = (min_rtt_r != '0);
    min_upd = (sample < min_rtt_r) ? sample : min_rtt_r;
    thresh  = {1'b0, min_upd} + {1'b0, delay};
    // ack delay only taken off when it cannot push the sample below min
    adj     = ({1'b0, sample} >= thresh) ? (sample - delay) : sample;
    diff    = (smoothed_r >= adj) ? (smoothed_r - adj) : (adj - smoothed_r);
    var_sum  = {1'b0, variance_r, 1'b0} + {2'b00, variance_r} + {2'b00, diff};
    srtt_sum = {smoothed_r, 3'b000} - {3'b000, smoothed_r} + {3'b000, adj};

    if (seeded) begin
      smoothed_nxt = srtt_sum[RTT_BITS+2:3];
      variance_nxt = var_sum[RTT_BITS+1:2];
      min_rtt_nxt  = min_upd;
    end else begin
      smoothed_nxt = sample;
      variance_nxt = sample >> 1;
      min_rtt_nxt  = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      variance_r <= '0;
      min_rtt_r  <= '0;
    end else if (load) begin
      smoothed_r <= smoothed_nxt;
      variance_r <= variance_nxt;
      min_rtt_r  <= min_rtt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      backoff_r <= backoff;
    end
  end

  assign smoothed  = smoothed_r;
  assign variance  = variance_r;
  assign min_rtt   = min_rtt_r;
  assign backoff_o = backoff_r;

endmodule

### src/rtte_pto.sv
// ----------------------------------------------------------------------------
// rtte_pto
// PTO durations from the updated state, registered with the result fields.
// ----------------------------------------------------------------------------
module rtte_pto #(
  parameter int RTT_BITS = rtte_pkg::RTT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [RTT_BITS-1:0]         smoothed,
  input  logic [RTT_BITS-1:0]         variance,
  input  logic [RTT_BITS-1:0]         min_rtt,
  input  logic [rtte_pkg::CNT_W-1:0]  backoff,
  input  logic [rtte_pkg::MAD_W-1:0]  peer_delay,
  input  logic [rtte_pkg::GRAN_W-1:0] timer_gran,
  output logic [RTT_BITS-1:0]         smoothed_o,
  output logic [RTT_BITS-1:0]         variance_o,
  output logic [RTT_BITS-1:0]         min_rtt_o,
  output logic [rtte_pkg::PTO_W-1:0]  pto_hs_o,
  output logic [rtte_pkg::PTO_W-1:0]  pto_app_o
);

  localparam int TERM_W = RTT_BITS + 2;
  localparam int SH_W   = TERM_W + rtte_pkg::CNT_MAX;
  localparam int MS_W   = rtte_pkg::MAD_W + rtte_pkg::CNT_MAX;
  localparam int HS_W   = SH_W + 1;
  localparam int APP_W  = ((HS_W > MS_W) ? HS_W : MS_W) + 1;

  logic [TERM_W-1:0] term4;
  logic [TERM_W-1:0] term;
  logic [SH_W-1:0]   term_sh;
  logic [MS_W-1:0]   mad_sh;
  logic [APP_W-1:0]  hs_wide;
  logic [APP_W-1:0]  app_wide;
  logic [APP_W-1:0]  sat_lim;
  logic [rtte_pkg::PTO_W-1:0] pto_hs_nxt, pto_app_nxt;

  logic [RTT_BITS-1:0]        smoothed_r, variance_r, min_rtt_r;
  logic [rtte_pkg::PTO_W-1:0] pto_hs_r, pto_app_r;

  always_comb begin
    term4    = {variance, 2'b00};
    term     = (term4 < TERM_W'(timer_gran)) ? TERM_W'(timer_gran) : term4;
    term_sh  = SH_W'(term) << backoff;
    mad_sh   = MS_W'(peer_delay) << backoff;
    hs_wide  = APP_W'(smoothed) + APP_W'(term_sh);
    app_wide = hs_wide + APP_W'(mad_sh);
    sat_lim  = APP_W'({rtte_pkg::PTO_W{1'b1}});
    pto_hs_nxt  = (hs_wide > sat_lim) ? {rtte_pkg::PTO_W{1'b1}}
                                      : rtte_pkg::PTO_W'(hs_wide);
    pto_app_nxt = (app_wide > sat_lim) ? {rtte_pkg::PTO_W{1'b1}}
                                       : rtte_pkg::PTO_W'(app_wide);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smoothed_r <= smoothed;
      variance_r <= variance;
      min_rtt_r  <= min_rtt;
      pto_hs_r   <= pto_hs_nxt;
      pto_app_r  <= pto_app_nxt;
    end
  end

  assign smoothed_o = smoothed_r;
  assign variance_o = variance_r;
  assign min_rtt_o  = min_rtt_r;
  assign pto_hs_o   = pto_hs_r;
  assign pto_app_o  = pto_app_r;

endmodule

### src/rtt_estimator_with_pto.sv
// ----------------------------------------------------------------------------
// rtt_estimator_with_pto
// RTT estimator (smoothed, variance, minimum) with PTO duration outputs.
// ----------------------------------------------------------------------------
// Pipeline: input register, state register, result register; out_tvalid
//   is driven from the result register.
// Throughput: one transaction per cycle unless out_tready stalls the output;
//   the state update is combinational between input and state registers.
// Reset: synchronous, active low; clears pipeline valids and the state, and
//   restores the peer max delay to 25 and timer_granularity to 1.
module rtt_estimator_with_pto #(
  parameter  int RTT_BITS = rtte_pkg::RTT_BITS_DEF,
  localparam int IN_W     = ((2 * RTT_BITS + rtte_pkg::CNT_W + 7) / 8) * 8,
  localparam int OUT_W    = ((3 * RTT_BITS + 2 * rtte_pkg::PTO_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // rtt sample, ack delay, backoff count (from bit 0 up)
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // smoothed_rtt, rtt_variance, minimum_rtt, pto_handshake, pto_application
  output logic [OUT_W-1:0]                out_tdata,
  input  logic                            cfg_we,
  input  logic [rtte_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rtte_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [rtte_pkg::MAD_W-1:0]  peer_delay_r;
  logic [rtte_pkg::GRAN_W-1:0] timer_gran_r;

  logic v1_r, v2_r, v3_r;
  logic [RTT_BITS-1:0]        sample_r, delay_r;
  logic [rtte_pkg::CNT_W-1:0] cnt_r;

  logic in_acc, out_acc, ready2, ready3, ld2, ld3;

  logic [RTT_BITS-1:0]        st_smoothed, st_variance, st_min;
  logic [rtte_pkg::CNT_W-1:0] st_cnt;
  logic [RTT_BITS-1:0]        o_smoothed, o_variance, o_min;
  logic [rtte_pkg::PTO_W-1:0] o_hs, o_app;

  // stall chain: each stage moves when the next one is empty or moving
  assign ready3    = !v3_r || out_tready;
  assign ready2    = !v2_r || ready3;
  assign in_tready = !v1_r || ready2;
  assign ld2       = v1_r && ready2;
  assign ld3       = v2_r && ready3;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = v3_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ld3) begin
        v2_r <= 1'b0;
      end
      if (ld3) begin
        v3_r <= 1'b1;
      end else if (out_acc) begin
        v3_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[RTT_BITS-1:0];
      delay_r  <= in_tdata[2*RTT_BITS-1:RTT_BITS];
      cnt_r    <= in_tdata[2*RTT_BITS+rtte_pkg::CNT_W-1:2*RTT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_delay_r <= rtte_pkg::MAD_RESET;
      timer_gran_r <= rtte_pkg::GRAN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rtte_pkg::REG_PEER_DELAY: peer_delay_r <= cfg_wdata[rtte_pkg::MAD_W-1:0];
        rtte_pkg::REG_TIMER_GRAN: timer_gran_r <= cfg_wdata[rtte_pkg::GRAN_W-1:0];
        default: ;
      endcase
    end
  end

  rtte_update #(.RTT_BITS(RTT_BITS)) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ld2),
    .sample    (sample_r),
    .delay     (delay_r),
    .backoff   (cnt_r),
    .smoothed  (st_smoothed),
    .variance  (st_variance),
    .min_rtt   (st_min),
    .backoff_o (st_cnt)
  );

  rtte_pto #(.RTT_BITS(RTT_BITS)) u_pto (
    .clk        (clk),
    .load       (ld3),
    .smoothed   (st_smoothed),
    .variance   (st_variance),
    .min_rtt    (st_min),
    .backoff    (st_cnt),
    .peer_delay (peer_delay_r),
    .timer_gran (timer_gran_r),
    .smoothed_o (o_smoothed),
    .variance_o (o_variance),
    .min_rtt_o  (o_min),
    .pto_hs_o   (o_hs),
    .pto_app_o  (o_app)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = OUT_W'({o_app, o_hs, o_min, o_variance, o_smoothed});

endmodule

### src/rtte_checker.sv
// ----------------------------------------------------------------------------
// rtte_checker
// Port-level checks for the RTT estimator, bound to the top level.
// ----------------------------------------------------------------------------
module rtte_checker #(
  parameter  int RTT_BITS = rtte_pkg::RTT_BITS_DEF,
  localparam int OUT_W    = ((3 * RTT_BITS + 2 * rtte_pkg::PTO_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int HS_LO  = 3 * RTT_BITS;
  localparam int APP_LO = HS_LO + rtte_pkg::PTO_W;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;   // transactions in flight, pipeline holds three

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result without a pending input");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_acc |-> pend_r != 2'd3)
    else $error("input taken with pipeline full");

  a_app_ge_hs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[APP_LO+rtte_pkg::PTO_W-1:APP_LO]
                   >= out_tdata[HS_LO+rtte_pkg::PTO_W-1:HS_LO])
    else $error("application PTO below handshake PTO");

endmodule

bind rtt_estimator_with_pto rtte_checker #(.RTT_BITS(RTT_BITS)) u_rtte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rtt_estimator_with_pto. A local estimator tracks
// min/smoothed/variance and the two PTO durations for every accepted sample.
// Each result transaction is checked field by field, in order. The run covers
// directed seeding and saturation cases, register extremes, a long receiver
// hold-off, and random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int RTT_W      = rtte_pkg::RTT_BITS_DEF;
  localparam int CNT_W      = rtte_pkg::CNT_W;
  localparam int CNT_MAX    = rtte_pkg::CNT_MAX;
  localparam int PTO_W      = rtte_pkg::PTO_W;
  localparam int MAD_W      = rtte_pkg::MAD_W;
  localparam int GRAN_W     = rtte_pkg::GRAN_W;
  localparam int CFG_ADDR_W = rtte_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = rtte_pkg::CFG_DATA_W;
  localparam int IN_W       = ((2 * RTT_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_W      = ((3 * RTT_W + 2 * PTO_W + 7) / 8) * 8;
  localparam int HOLD_LEN   = 120;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_LEN  = 12;

  typedef struct packed {
    bit [PTO_W-1:0] pto_app;
    bit [PTO_W-1:0] pto_hs;
    bit [RTT_W-1:0] minimum;
    bit [RTT_W-1:0] variance;
    bit [RTT_W-1:0] smoothed;
  } rtt_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // rtt sample, ack delay, backoff count
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // smoothed, variance, minimum, pto_hs, pto_app
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // estimator copy kept by the bench
  bit [RTT_W-1:0]  est_smoothed;
  bit [RTT_W-1:0]  est_variance;
  bit [RTT_W-1:0]  est_min;
  bit [MAD_W-1:0]  est_mad;
  bit [GRAN_W-1:0] est_gran;

  rtt_report_t expected_reports[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  rtt_estimator_with_pto DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rtt_report_t advance_estimate(bit [RTT_W-1:0] sample,
                                                   bit [RTT_W-1:0] delay,
                                                   bit [CNT_W-1:0] count);
    rtt_report_t rep;
    bit [63:0]   adj;
    bit [63:0]   diff;
    bit [63:0]   term;
    bit [63:0]   hs;
    bit [63:0]   app;
    if (est_min == '0) begin
      est_smoothed = sample;
      est_variance = sample >> 1;
      est_min      = sample;
    end else begin
      adj = 64'(sample);
      if (sample < est_min) est_min = sample;
      // ack delay is only taken off when it cannot push below min_rtt
      if (64'(sample) >= 64'(est_min) + 64'(delay)) adj = 64'(sample) - 64'(delay);
      diff = (64'(est_smoothed) >= adj) ? 64'(est_smoothed) - adj : adj - 64'(est_smoothed);
      est_variance = RTT_W'((64'(est_variance) * 3 + diff) >> 2);
      est_smoothed = RTT_W'((64'(est_smoothed) * 7 + adj) >> 3);
    end
    term = 64'(est_variance) << 2;
    if (term < 64'(est_gran)) term = 64'(est_gran);
    hs  = 64'(est_smoothed) + (term << count);
    app = hs + (64'(est_mad) << count);
    rep.smoothed = est_smoothed;
    rep.variance = est_variance;
    rep.minimum  = est_min;
    rep.pto_hs   = (hs  > 64'hFFFF_FFFF) ? '1 : hs[PTO_W-1:0];
    rep.pto_app  = (app > 64'hFFFF_FFFF) ? '1 : app[PTO_W-1:0];
    return rep;
  endfunction

  task automatic send_sample(bit [RTT_W-1:0] sample, bit [RTT_W-1:0] delay,
                             bit [CNT_W-1:0] count);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({count, delay, sample});
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(advance_estimate(sample, delay, count));
  endtask

  // drop valid, then let the pipeline drain before touching registers
  task automatic wait_idle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == rtte_pkg::REG_PEER_DELAY) est_mad = data[MAD_W-1:0];
    else if (idx == rtte_pkg::REG_TIMER_GRAN) est_gran = data[GRAN_W-1:0];
  endtask

  task automatic test_seed_and_extremes();
    send_sample(20'd0, 20'd0, 4'd0);          // zero sample seeds zeros
    send_sample(20'd0, 20'd7, 4'd1);          // still unseeded
    send_sample(20'd100, 20'd0, 4'd0);        // real seed
    send_sample(20'hFFFFF, 20'hFFFFF, 4'd15); // widest fields
    send_sample(20'd50, 20'd0, 4'd2);         // new minimum
    send_sample(20'd200, 20'd30, 4'd3);       // delay subtracted
    send_sample(20'd60, 20'd20, 4'd4);        // delay would go below min
    send_sample(20'd0, 20'd0, 4'd5);          // minimum drops to zero
    send_sample(20'hFFFFF, 20'd0, 4'd15);     // reseed at max, PTO saturates
    send_sample(20'hFFFFF, 20'h00001, 4'd15);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(rtte_pkg::REG_PEER_DELAY, '0);
    write_reg(rtte_pkg::REG_TIMER_GRAN, 14'h3F00);  // upper bits dropped: granularity 0
    send_sample(20'd0, 20'd0, 4'd0);
    send_sample(20'd0, 20'd0, 4'd9);         // zero variance, zero granularity
    send_sample(20'd40, 20'd5, 4'd0);
    wait_idle();
    write_reg(rtte_pkg::REG_PEER_DELAY, 14'h3FFF);
    write_reg(rtte_pkg::REG_TIMER_GRAN, 14'h3FFF);  // masked to 255
    send_sample(20'd0, 20'd0, 4'd15);
    send_sample(20'd0, 20'd0, 4'd15);
    send_sample(20'd3, 20'd1, 4'd15);
    send_sample(20'd1, 20'hFFFFF, 4'd0);
    send_sample(20'h80000, 20'h7FFFF, 4'd12);
    wait_idle();
  endtask

  task automatic random_sample();
    bit [RTT_W-1:0] sample;
    bit [RTT_W-1:0] delay;
    bit [CNT_W-1:0] count;
    int             r;
    r = $urandom_range(0, 99);
    if (r < 3)       sample = '0;
    else if (r < 60) sample = RTT_W'($urandom_range(1, 2000));
    else if (r < 80) sample = RTT_W'($urandom_range(1, 300));
    else             sample = RTT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20)      delay = '0;
    else if (r < 70) delay = RTT_W'($urandom_range(0, 200));
    else if (r < 85) delay = RTT_W'($urandom_range(0, int'(sample)));
    else             delay = RTT_W'($urandom);
    count = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(0, 3))
                                        : CNT_W'($urandom_range(0, CNT_MAX));
    send_sample(sample, delay, count);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (60) random_sample();
    wait_idle();
  endtask

  task automatic test_random_phase(int n_items, bit calm);
    write_reg(rtte_pkg::REG_PEER_DELAY, CFG_DATA_W'($urandom));
    write_reg(rtte_pkg::REG_TIMER_GRAN, CFG_DATA_W'($urandom));
    quiet = calm;
    repeat (n_items) random_sample();
    wait_idle();
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rtt_report_t exp_rep;
    rtt_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(rtt_report_t)-1:0];
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction: %h", got);
        mismatch_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.smoothed != exp_rep.smoothed) begin
          $error("smoothed_rtt exp %0d got %0d", exp_rep.smoothed, got.smoothed);
          mismatch_count++;
        end
        if (got.variance != exp_rep.variance) begin
          $error("rtt_variance exp %0d got %0d", exp_rep.variance, got.variance);
          mismatch_count++;
        end
        if (got.minimum != exp_rep.minimum) begin
          $error("minimum_rtt exp %0d got %0d", exp_rep.minimum, got.minimum);
          mismatch_count++;
        end
        if (got.pto_hs != exp_rep.pto_hs) begin
          $error("pto_handshake exp %0d got %0d", exp_rep.pto_hs, got.pto_hs);
          mismatch_count++;
        end
        if (got.pto_app != exp_rep.pto_app) begin
          $error("pto_application exp %0d got %0d", exp_rep.pto_app, got.pto_app);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    est_smoothed = '0;
    est_variance = '0;
    est_min      = '0;
    est_mad      = rtte_pkg::MAD_RESET;
    est_gran     = rtte_pkg::GRAN_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_seed_and_extremes();
    test_config_extremes();
    test_backpressure();
    test_random_phase(300, 1'b0);
    test_random_phase(300, 1'b0);
    test_random_phase(300, 1'b0);
    test_random_phase(300, 1'b1);

    repeat (DRAIN_LEN) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
src/rtte_pkg.sv
src/rtte_update.sv
src/rtte_pto.sv
src/rtt_estimator_with_pto.sv
src/rtte_checker.sv
verif/tb.sv
